@@ hdl/hrhp_pkg.sv @@
package hrhp_pkg;

	// Character codes, after case folding
	localparam logic [7:0] CH_SP       = 8'h20;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	// Method table
	localparam int NUM_METHODS = 9;

	localparam logic [3:0] METHOD_UNKNOWN = 4'd0;

	// Status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_EMPTY_REQ   = 2'd1;
	localparam logic [1:0] ST_EMPTY_CLEN  = 2'd2;
	localparam logic [1:0] ST_NO_HOST     = 2'd3;

	// Counter limits and header name lengths
	localparam logic [3:0] TOKEN_MAX = 4'd15;
	localparam logic [4:0] LINE_MAX  = 5'd31;
	localparam logic [4:0] HOST_LEN  = 5'd5;
	localparam logic [4:0] CLEN_LEN  = 5'd15;

	localparam logic [39:0]  HOST_NAME = "host:";
	localparam logic [119:0] CLEN_NAME = "content-length:";

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Event operation codes
	typedef enum logic [1:0] {
		OP_NONE,
		OP_CHAR,
		OP_EOL
	} op_t;

	// One classified event: an optional held-back CR, then a char, a line end or nothing
	typedef struct packed {
		logic       pre_cr;
		op_t        op;
		logic [7:0] ch;
	} evt_t;

	// Method name, left-justified, zero padded
	function automatic logic [63:0] method_name(input logic [3:0] idx);
		logic [63:0] nm;
		case (idx)
			4'd0:    nm = {"get", 40'h0};
			4'd1:    nm = {"post", 32'h0};
			4'd2:    nm = {"head", 32'h0};
			4'd3:    nm = {"put", 40'h0};
			4'd4:    nm = {"delete", 16'h0};
			4'd5:    nm = {"connect", 8'h0};
			4'd6:    nm = {"options", 8'h0};
			4'd7:    nm = {"trace", 24'h0};
			4'd8:    nm = {"patch", 24'h0};
			default: nm = 64'h0;
		endcase
		return nm;
	endfunction

	function automatic logic [3:0] method_len(input logic [3:0] idx);
		logic [3:0] len;
		case (idx)
			4'd0:    len = 4'd3;
			4'd1:    len = 4'd4;
			4'd2:    len = 4'd4;
			4'd3:    len = 4'd3;
			4'd4:    len = 4'd6;
			4'd5:    len = 4'd7;
			4'd6:    len = 4'd7;
			4'd7:    len = 4'd5;
			4'd8:    len = 4'd5;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

endpackage

@@ hdl/hrhp_front.sv @@
module hrhp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	output logic              evt_valid,
	output hrhp_pkg::evt_t    evt
);
	import hrhp_pkg::*;

	logic       after_cr_q;
	logic       after_cr_d;
	logic [7:0] ch;

	// Fold to lower case, then split off CR handling
	always_comb begin
		ch = in_byte;
		if (in_byte inside {[8'h41:8'h5A]}) begin
			ch = in_byte + CASE_OFFSET;
		end
		evt.pre_cr = 1'b0;
		evt.op     = OP_NONE;
		evt.ch     = ch;
		after_cr_d = after_cr_q;
		if (after_cr_q && ch == CH_LF) begin
			evt.op     = OP_EOL;
			after_cr_d = 1'b0;
		end else begin
			evt.pre_cr = after_cr_q;
			if (ch == CH_CR) begin
				after_cr_d = 1'b1;
			end else if (ch == CH_LF) begin
				evt.op     = OP_EOL;
				after_cr_d = 1'b0;
			end else begin
				evt.op     = OP_CHAR;
				after_cr_d = 1'b0;
			end
		end
		evt_valid = in_valid && (evt.pre_cr || evt.op != OP_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_cr_q <= 1'b0;
		end else if (in_valid) begin
			after_cr_q <= after_cr_d;
		end
	end

endmodule

@@ hdl/hrhp_fifo.sv @@
module hrhp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  hrhp_pkg::evt_t    wr_data,
	output logic              full,
	input  logic              rd_en,
	output hrhp_pkg::evt_t    rd_data,
	output logic              not_empty
);
	import hrhp_pkg::*;

	evt_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_wr;
	logic                do_rd;

	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/hrhp_back.sv @@
module hrhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	input  hrhp_pkg::evt_t    evt,
	output logic              evt_take,
	output logic              empty,
	input  logic              pop,
	output logic [3:0]        method_code,
	output logic [1:0]        status_code,
	output logic              host_present
);
	import hrhp_pkg::*;

	typedef struct packed {
		logic                   hdr;
		logic [NUM_METHODS-1:0] cand;
		logic [3:0]             tok_len;
		logic                   tok_done;
		logic [4:0]             line_len;
		logic [1:0]             hn;
		logic                   host_seen;
		logic                   elen_seen;
	} st_t;

	localparam st_t ST_INIT = '{
		hdr:       1'b0,
		cand:      '1,
		tok_len:   '0,
		tok_done:  1'b0,
		line_len:  '0,
		hn:        2'b11,
		host_seen: 1'b0,
		elen_seen: 1'b0
	};

	function automatic st_t feed(input st_t s, input logic [7:0] c);
		st_t         r;
		logic [63:0] nm;
		r  = s;
		nm = '0;
		if (!s.hdr) begin
			if (!s.tok_done) begin
				if (c == CH_SP) begin
					if (s.tok_len != '0) begin
						r.tok_done = 1'b1;
					end
				end else begin
					for (int i = 0; i < NUM_METHODS; i++) begin
						nm = method_name(4'(i));
						if (s.tok_len >= method_len(4'(i)) ||
							nm[63 - 8*int'(s.tok_len[2:0]) -: 8] != c) begin
							r.cand[i] = 1'b0;
						end
					end
					if (s.tok_len < TOKEN_MAX) begin
						r.tok_len = s.tok_len + 4'd1;
					end
				end
			end
		end else begin
			if (s.line_len < HOST_LEN && s.hn[0] &&
				HOST_NAME[39 - 8*int'(s.line_len[2:0]) -: 8] != c) begin
				r.hn[0] = 1'b0;
			end
			if (s.line_len < CLEN_LEN && s.hn[1] &&
				CLEN_NAME[119 - 8*int'(s.line_len[3:0]) -: 8] != c) begin
				r.hn[1] = 1'b0;
			end
		end
		if (s.line_len < LINE_MAX) begin
			r.line_len = s.line_len + 5'd1;
		end
		return r;
	endfunction

	// Lowest-numbered surviving method whose length equals the token length
	function automatic logic [3:0] decide(input st_t s);
		logic [3:0] m;
		m = METHOD_UNKNOWN;
		if (s.tok_len != '0) begin
			for (int i = NUM_METHODS - 1; i >= 0; i--) begin
				if (s.cand[i] && method_len(4'(i)) == s.tok_len) begin
					m = 4'(i + 1);
				end
			end
		end
		return m;
	endfunction

	st_t        st_q;
	st_t        st_mid;
	st_t        st_d;
	logic       emit;
	logic [3:0] res_method;
	logic [1:0] res_status;
	logic       res_host;
	logic       out_valid_q;
	logic       go;

	assign go       = evt_valid && (!out_valid_q || pop);
	assign evt_take = go;
	assign empty    = !out_valid_q;

	always_comb begin
		st_mid     = evt.pre_cr ? feed(st_q, CH_CR) : st_q;
		st_d       = st_mid;
		emit       = 1'b0;
		res_method = METHOD_UNKNOWN;
		res_status = ST_OK;
		res_host   = 1'b0;
		case (evt.op)
			OP_CHAR: begin
				st_d = feed(st_mid, evt.ch);
			end
			OP_EOL: begin
				if (st_mid.line_len == '0) begin
					emit = 1'b1;
					st_d = ST_INIT;
					if (!st_mid.hdr) begin
						res_status = ST_EMPTY_REQ;
					end else begin
						res_method = decide(st_mid);
						res_host   = st_mid.host_seen;
						if (st_mid.elen_seen) begin
							res_status = ST_EMPTY_CLEN;
						end else if (!st_mid.host_seen) begin
							res_status = ST_NO_HOST;
						end
					end
				end else begin
					if (!st_mid.hdr) begin
						st_d.hdr      = 1'b1;
						st_d.tok_done = 1'b1;
					end else begin
						if (st_mid.hn[0] && st_mid.line_len >= HOST_LEN) begin
							st_d.host_seen = 1'b1;
						end
						if (st_mid.hn[1] && st_mid.line_len == CLEN_LEN) begin
							st_d.elen_seen = 1'b1;
						end
					end
					st_d.line_len = '0;
					st_d.hn       = 2'b11;
				end
			end
			default: begin
				st_d = st_mid;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				st_q <= st_d;
			end
			if (go && emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			method_code  <= res_method;
			status_code  <= res_status;
			host_present <= res_host;
		end
	end

endmodule

@@ hdl/http_request_head_parser.sv @@
// The event of a head's final LF is written into the event queue; once it leaves the queue and
// the result register is free, the head's result loads the result register.
// Throughput: one byte per cycle while the event queue has room; set by the update of the
// match state in the back end. Reset: arst_n clears the CR hold, the event queue,
// the match state and the result valid flag at once; no clearing pass follows.
module http_request_head_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] method_code,
	output logic [1:0] status_code,
	output logic       host_present
);
	import hrhp_pkg::*;

	// Front end: fold case and resolve CR/LF pairs into events.
	// A held-back CR rides along with the next event as pre_cr, so every byte
	// yields at most one event and bytes that only start a CR hold yield none.
	logic front_valid;
	evt_t front_evt;

	// Queue status and back-end side
	logic q_full;
	logic q_not_empty;
	evt_t q_evt;
	logic back_take;
	logic in_xfer;

	// Accept a byte whenever the event queue has room; the queue absorbs
	// back-end stalls caused by a full result register.
	assign full    = q_full;
	assign in_xfer = push && !q_full;

	hrhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_xfer),
		.in_byte   (data_byte),
		.evt_valid (front_valid),
		.evt       (front_evt)
	);

	// Short event queue between the classifier and the matcher
	hrhp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (front_valid),
		.wr_data   (front_evt),
		.full      (q_full),
		.rd_en     (back_take),
		.rd_data   (q_evt),
		.not_empty (q_not_empty)
	);

	// Back end: advance method/header match state, drop a finished head into
	// the result register, and hold it until the consumer pops it. An event is
	// taken in the same cycle that the waiting result transfers out.
	hrhp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt_valid    (q_not_empty),
		.evt          (q_evt),
		.evt_take     (back_take),
		.empty        (empty),
		.pop          (pop),
		.method_code  (method_code),
		.status_code  (status_code),
		.host_present (host_present)
	);

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import hrhp_pkg::*;

	// Method codes as the block reports them
	localparam logic [3:0] M_GET     = 4'd1;
	localparam logic [3:0] M_POST    = 4'd2;
	localparam logic [3:0] M_HEAD    = 4'd3;
	localparam logic [3:0] M_PUT     = 4'd4;
	localparam logic [3:0] M_DELETE  = 4'd5;
	localparam logic [3:0] M_CONNECT = 4'd6;
	localparam logic [3:0] M_OPTIONS = 4'd7;
	localparam logic [3:0] M_TRACE   = 4'd8;
	localparam logic [3:0] M_PATCH   = 4'd9;

	localparam int DIRECTED_ROWS = 16;
	localparam int RANDOM_BYTES  = 1950;
	localparam int MIN_HEADS     = 40;
	localparam int QUIET_TAIL    = 200;   // last bytes of the plan go without idling
	localparam int HOLD_AT       = 5;     // results taken before the long receiver hold-off
	localparam int HOLD_LEN      = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int TAIL_CYCLES   = 20;

	typedef struct packed {
		logic [3:0] method;
		logic [1:0] status;
		logic       host;
	} head_result_t;

	// One byte of the plan; a directed row may pin the result its last byte causes
	typedef struct packed {
		logic [7:0]   value;
		bit           typed;
		head_result_t typed_res;
	} plan_byte_t;

	typedef enum logic [1:0] {
		ON_REQUEST_LINE,
		ON_HEADER_LINES
	} parse_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [3:0] method_code;
	logic [1:0] status_code;
	logic       host_present;

	plan_byte_t   bytes_to_send[$];
	head_result_t heads_due[$];
	plan_byte_t   in_flight;

	int bytes_accepted = 0;
	int results_taken  = 0;
	int failures       = 0;

	// Idle control for both sides
	int send_gap       = 0;
	int recv_gap       = 0;
	int hold_cycles    = 0;
	bit send_gaps_on   = 1'b1;
	bit recv_gaps_on   = 1'b1;
	bit hold_done      = 1'b0;

	// Parser state mirrored by the predictor
	parse_phase_t phase_now;
	logic [8:0]   still_method;   // bit m set while the token can still be method m+1
	logic [3:0]   tok_len;
	logic         tok_done;
	logic [4:0]   line_len;
	logic [1:0]   name_still;     // bit 0 "host:", bit 1 "content-length:"
	logic         cr_held;
	logic         saw_host;
	logic         saw_empty_clen;

	string host_word = "host:";
	string clen_word = "content-length:";

	http_request_head_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.method_code  (method_code),
		.status_code  (status_code),
		.host_present (host_present)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic string method_word(input int idx);
		case (idx)
			0:       return "get";
			1:       return "post";
			2:       return "head";
			3:       return "put";
			4:       return "delete";
			5:       return "connect";
			6:       return "options";
			7:       return "trace";
			8:       return "patch";
			default: return "";
		endcase
	endfunction

	// Return to the state of a fresh head
	task restart_head();
		phase_now      = ON_REQUEST_LINE;
		still_method   = '1;
		tok_len        = '0;
		tok_done       = 1'b0;
		line_len       = '0;
		name_still     = '1;
		cr_held        = 1'b0;
		saw_host       = 1'b0;
		saw_empty_clen = 1'b0;
	endtask

	// Advance the match state by one ordinary line character (already folded)
	task take_char(input logic [7:0] c);
		string w;
		if (phase_now == ON_REQUEST_LINE) begin
			if (!tok_done) begin
				if (c == CH_SP) begin
					// leading spaces are skipped, the first space after the token closes it
					if (tok_len != 0)
						tok_done = 1'b1;
				end else begin
					for (int m = 0; m < NUM_METHODS; m++) begin
						w = method_word(m);
						if (tok_len >= w.len() || w[tok_len] != c)
							still_method[m] = 1'b0;
					end
					if (tok_len != TOKEN_MAX)
						tok_len++;
				end
			end
		end else begin
			if (line_len < HOST_LEN && name_still[0] && host_word[line_len] != c)
				name_still[0] = 1'b0;
			if (line_len < CLEN_LEN && name_still[1] && clen_word[line_len] != c)
				name_still[1] = 1'b0;
		end
		if (line_len != LINE_MAX)
			line_len++;
	endtask

	// Close the current line; an empty line ends the head and yields its result
	task finish_line(output bit emitted, output head_result_t res);
		string w;
		emitted = 1'b0;
		res     = '0;
		if (phase_now == ON_REQUEST_LINE) begin
			if (line_len == 0) begin
				emitted = 1'b1;
				res     = {METHOD_UNKNOWN, ST_EMPTY_REQ, 1'b0};
				restart_head();
			end else begin
				phase_now  = ON_HEADER_LINES;
				tok_done   = 1'b1;
				line_len   = '0;
				name_still = '1;
			end
		end else if (line_len == 0) begin
			emitted    = 1'b1;
			res.method = METHOD_UNKNOWN;
			// walk down so the lowest matching method wins
			if (tok_len != 0) begin
				for (int m = NUM_METHODS - 1; m >= 0; m--) begin
					w = method_word(m);
					if (still_method[m] && w.len() == tok_len)
						res.method = 4'(m + 1);
				end
			end
			// an empty content-length outranks a missing host
			if (saw_empty_clen)
				res.status = ST_EMPTY_CLEN;
			else if (!saw_host)
				res.status = ST_NO_HOST;
			else
				res.status = ST_OK;
			res.host = saw_host;
			restart_head();
		end else begin
			if (name_still[0] && line_len >= HOST_LEN)
				saw_host = 1'b1;
			if (name_still[1] && line_len == CLEN_LEN)
				saw_empty_clen = 1'b1;
			line_len   = '0;
			name_still = '1;
		end
	endtask

	// Fold case, resolve a held-back CR, then update the state for one raw byte
	task parse_byte(input logic [7:0] raw, output bit emitted, output head_result_t res);
		logic [7:0] c;
		emitted = 1'b0;
		res     = '0;
		c = (raw >= "A" && raw <= "Z") ? raw + CASE_OFFSET : raw;
		if (cr_held) begin
			cr_held = 1'b0;
			// a CR that is not followed by LF counts as a line character
			if (c != CH_LF)
				take_char(CH_CR);
		end
		if (c == CH_CR)
			cr_held = 1'b1;
		else if (c == CH_LF)
			finish_line(emitted, res);
		else
			take_char(c);
	endtask

	// ------------------------------------------------------------------
	// Stimulus plan
	// ------------------------------------------------------------------

	function automatic logic [7:0] random_char(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	task add_byte(input logic [7:0] b);
		plan_byte_t item;
		item.value     = b;
		item.typed     = 1'b0;
		item.typed_res = '0;
		bytes_to_send.push_back(item);
	endtask

	// Append a word, upper-casing letters at random when mix is set
	task add_word(input string s, input bit mix);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1))
				c = c - CASE_OFFSET;
			add_byte(c);
		end
	endtask

	// Line ending: mostly CRLF, often a bare LF, now and then a stray CR in front
	task add_eol();
		int r;
		r = $urandom_range(0, 9);
		if (r == 9)
			add_byte(CH_CR);
		if (r < 6 || r == 9)
			add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	// Directed table: text of one head, and its result where it is obvious
	task automatic directed_row(input int r, output string text, output bit typed,
	                            output head_result_t res);
		typed = 1'b1;
		res   = '0;
		case (r)
			0:  begin text = "\n";   res = {METHOD_UNKNOWN, ST_EMPTY_REQ, 1'b0}; end
			1:  begin text = "\r\n"; res = {METHOD_UNKNOWN, ST_EMPTY_REQ, 1'b0}; end
			2:  begin text = "GET\nhost:\n\n"; res = {M_GET, ST_OK, 1'b1}; end
			3:  begin text = "  pAtCh x\r\nHost:y\r\n\r\n"; res = {M_PATCH, ST_OK, 1'b1}; end
			4:  begin text = "delete\n\n"; res = {M_DELETE, ST_NO_HOST, 1'b0}; end
			5:  begin
				text = "POST\ncontent-length:\n\n";
				res  = {M_POST, ST_EMPTY_CLEN, 1'b0};
			end
			6:  begin
				text = "connect\nhost: a\ncontent-length:\r\n\r\n";
				res  = {M_CONNECT, ST_EMPTY_CLEN, 1'b1};
			end
			7:  begin text = "getx\nhost:\n\n"; res = {METHOD_UNKNOWN, ST_OK, 1'b1}; end
			8:  begin text = "   \nhost:\n\n"; res = {METHOD_UNKNOWN, ST_OK, 1'b1}; end
			9:  begin text = "options\nhost\n\n"; res = {M_OPTIONS, ST_NO_HOST, 1'b0}; end
			10: begin
				text = "trace\ncontent-length:5\nhost:\n\n";
				res  = {M_TRACE, ST_OK, 1'b1};
			end
			11: begin text = "head\r\r\nhost:\n\n"; typed = 1'b0; end
			12: begin text = "put\nxhost:\n\n"; res = {M_PUT, ST_NO_HOST, 1'b0}; end
			13: begin text = "GETGETGETGETGETGETGET\n\n"; typed = 1'b0; end
			14: begin text = "get \377\nhost:\n\n"; res = {M_GET, ST_OK, 1'b1}; end
			default: begin text = "HEAD /\r\nhost:\r\n\r\n"; res = {M_HEAD, ST_OK, 1'b1}; end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender: offer plan bytes, predict on every transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin : sender
		bit           sent;
		bit           offer;
		bit           emitted;
		head_result_t res;
		if (arst_n) begin
			sent = push && !full;
			if (sent) begin
				parse_byte(in_flight.value, emitted, res);
				// a pinned row result takes the place of the predicted one
				if (in_flight.typed)
					heads_due.push_back(in_flight.typed_res);
				else if (emitted)
					heads_due.push_back(res);
				bytes_accepted++;
			end
			if ($urandom_range(0, 199) == 0)
				send_gaps_on = !send_gaps_on;
			if (push && !sent) begin
				offer = 1'b1;   // hold the byte until it is taken
			end else if (send_gap > 0) begin
				send_gap--;
				offer = 1'b0;
			end else if (bytes_to_send.size() == 0) begin
				offer = 1'b0;
			end else if (send_gaps_on && bytes_to_send.size() > QUIET_TAIL &&
			             $urandom_range(0, 5) == 0) begin
				// start an idle gap; send_gap holds the rest of it
				send_gap = $urandom_range(0, 6);
				offer    = 1'b0;
			end else begin
				in_flight = bytes_to_send.pop_front();
				data_byte <= in_flight.value;
				offer     = 1'b1;
			end
			push <= offer;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: check every result transfer against the oldest expectation
	// ------------------------------------------------------------------
	task report_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("mismatch: %s", msg);
	endtask

	always @(posedge clk) begin : receiver
		bit           take;
		head_result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				results_taken++;
				if (heads_due.size() == 0) begin
					report_failure($sformatf("result %0d with none expected: method %0d status %0d host %0d",
						results_taken, method_code, status_code, host_present));
				end else begin
					want = heads_due.pop_front();
					if (want.method !== method_code || want.status !== status_code ||
					    want.host !== host_present)
						report_failure($sformatf(
							"result %0d: method exp %0d got %0d, status exp %0d got %0d, host exp %0d got %0d",
							results_taken, want.method, method_code, want.status, status_code,
							want.host, host_present));
				end
			end
			// once, early on: hold off long enough for the block to back up
			if (!hold_done && results_taken >= HOLD_AT) begin
				hold_done   = 1'b1;
				hold_cycles = HOLD_LEN;
			end
			if ($urandom_range(0, 199) == 0)
				recv_gaps_on = !recv_gaps_on;
			if (hold_cycles > 0) begin
				hold_cycles--;
				take = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				take = 1'b0;
			end else if (recv_gaps_on && bytes_to_send.size() > QUIET_TAIL &&
			             $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 6);
				take     = 1'b0;
			end else begin
				take = 1'b1;
			end
			pop <= take;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run when no transfer happens for too long
	// ------------------------------------------------------------------
	initial begin : watchdog
		int stale;
		stale = 0;
		while (stale < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				stale = 0;
			else
				stale++;
		end
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main: build the plan, release reset, drain, report
	// ------------------------------------------------------------------
	initial begin : main
		string        text;
		bit           typed;
		head_result_t res;
		plan_byte_t   item;
		int           heads_made;
		int           pick;
		string        w;
		restart_head();

		// directed rows, each a complete head started from the idle state
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			directed_row(r, text, typed, res);
			for (int i = 0; i < text.len(); i++) begin
				item.value     = text[i];
				item.typed     = typed && (i == text.len() - 1);
				item.typed_res = res;
				bytes_to_send.push_back(item);
			end
		end

		// random part: mostly well-formed heads with random content, some noise
		heads_made = 0;
		while (bytes_to_send.size() < RANDOM_BYTES || heads_made < MIN_HEADS) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				heads_made++;
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) add_byte(CH_SP);
				pick = $urandom_range(0, 11);
				if (pick <= 7) begin
					add_word(method_word($urandom_range(0, 8)), 1'b1);
				end else if (pick == 8) begin
					// proper prefix of a method name
					w = method_word($urandom_range(0, 8));
					add_word(w.substr(0, $urandom_range(0, w.len() - 2)), 1'b1);
				end else if (pick == 9) begin
					add_word(method_word($urandom_range(0, 8)), 1'b1);
					add_byte(random_char("a", "z"));
				end else if (pick == 10) begin
					// random tokens of up to 20 letters can run the length counter into saturation
					repeat ($urandom_range(1, 20)) add_byte(random_char("a", "z"));
				end else begin
					add_byte(CH_SP);
				end
				if ($urandom_range(0, 3) != 0) begin
					add_byte(CH_SP);
					add_byte("/");
					repeat ($urandom_range(0, 5)) add_byte(random_char(33, 126));
					if ($urandom_range(0, 1))
						add_word(" HTTP/1.1", 1'b1);
				end
				add_eol();
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 9))
						0, 1: begin
							add_word("host:", 1'b1);
							if ($urandom_range(0, 1))
								add_word(" example", 1'b1);
						end
						2: begin
							if ($urandom_range(0, 1))
								add_word("host", 1'b1);
							else
								add_word("hos", 1'b1);
						end
						3: add_word("content-length:", 1'b1);
						4: begin
							add_word("content-length: ", 1'b1);
							repeat ($urandom_range(1, 4)) add_byte(random_char("0", "9"));
						end
						5: add_word("content-len", 1'b1);
						6: begin
							repeat ($urandom_range(1, 8)) add_byte(random_char("a", "z"));
							add_byte(":");
							repeat ($urandom_range(0, 6)) add_byte(random_char(33, 126));
						end
						7: repeat ($urandom_range(32, 40)) add_byte(random_char(33, 126));
						8: begin
							// a bare CR inside the name breaks the match
							add_word("ho", 1'b1);
							add_byte(CH_CR);
							add_word("st:", 1'b1);
						end
						default: begin
							add_byte(CH_SP);
							add_word("host:", 1'b1);
						end
					endcase
					add_eol();
				end
				add_eol();
			end else if (pick == 8) begin
				// raw noise over the full byte range, sometimes flushed by blank lines
				repeat ($urandom_range(1, 12)) add_byte(random_char(0, 255));
				if ($urandom_range(0, 1)) begin
					add_byte(CH_LF);
					add_byte(CH_LF);
				end
			end else begin
				add_eol();
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every byte taken, every result seen
		while (bytes_to_send.size() != 0 || push || heads_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0 && heads_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/hrhp_pkg.sv
hdl/hrhp_front.sv
hdl/hrhp_fifo.sv
hdl/hrhp_back.sv
hdl/http_request_head_parser.sv
tb/sv/testbench.sv
